/* sv/zglu_pkg.sv */
`timescale 1ns / 1ps

package zglu_pkg;

    localparam int LATTICE_SIDE = 8;
    localparam int REPLICAS     = 8;

    localparam int COORD_W   = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int REP_W     = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
    localparam int ROW_DEPTH = REPLICAS * LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE
                               * LATTICE_SIDE;
    localparam int ROW_W     = $clog2(ROW_DEPTH);
    localparam int DIRS      = 4;

    localparam int CFG_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;
    localparam int TOTAL_W   = 18;

    localparam logic [CFG_W-1:0] HALF_PROB = 33'h0_8000_0000;
    localparam logic [CFG_W-1:0] FULL_PROB = 33'h1_0000_0000;
    localparam int SUM_LIMIT = 98304;

    localparam logic [1:0] OP_HEAT    = 2'd0;
    localparam logic [1:0] OP_METRO   = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_S2   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_S4   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_S6   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METRO_E4  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_METRO_E8  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_METRO_E12 = 3'd5;

    typedef enum logic [2:0] {
        AM_SELF,
        AM_PLUS_D,
        AM_MINUS_P,
        AM_MINUS_P_PLUS_D,
        AM_PLUS_P
    } adr_mode_t;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_WAIT_IN,
        SQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        seq_t      seq;
        logic      rd_en;
        adr_mode_t mode;
        logic [1:0] k;
        logic      decide;
        logic      commit;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [ROW_W-1:0]     wr_addr;
        logic [DIRS-1:0]      wr_data;
    } mem_req_t;

    typedef logic [COORD_W-1:0] coord_t;

    // k-th direction other than d, in increasing order
    function automatic logic [1:0] other_dir(input logic [1:0] d, input logic [1:0] k);
        return (k < d) ? k : 2'(k + 2'd1);
    endfunction

    function automatic coord_t step_up(input coord_t c);
        return (c == COORD_W'(LATTICE_SIDE - 1)) ? '0 : COORD_W'(c + 1'b1);
    endfunction

    function automatic coord_t step_down(input coord_t c);
        return (c == '0) ? COORD_W'(LATTICE_SIDE - 1) : COORD_W'(c - 1'b1);
    endfunction

    function automatic logic [ROW_W-1:0] row_addr(input logic [REP_W-1:0] rep,
                                                  input coord_t c0, input coord_t c1,
                                                  input coord_t c2, input coord_t c3);
        logic [ROW_W-1:0] a;
        a = ROW_W'(rep);
        a = ROW_W'(a * ROW_W'(LATTICE_SIDE)) + ROW_W'(c0);
        a = ROW_W'(a * ROW_W'(LATTICE_SIDE)) + ROW_W'(c1);
        a = ROW_W'(a * ROW_W'(LATTICE_SIDE)) + ROW_W'(c2);
        a = ROW_W'(a * ROW_W'(LATTICE_SIDE)) + ROW_W'(c3);
        return a;
    endfunction

endpackage

/* sv/zglu_sequencer.sv */
`timescale 1ns / 1ps

module zglu_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  zglu_pkg::stat_t st,
    output zglu_pkg::ctrl_t cw
);

    logic [zglu_pkg::STEP_W-1:0] step_reg, step_next;

    function automatic zglu_pkg::ctrl_t mk(input zglu_pkg::seq_t seq, input logic rd_en,
                                           input zglu_pkg::adr_mode_t mode,
                                           input logic [1:0] k, input logic decide,
                                           input logic commit);
        zglu_pkg::ctrl_t c;
        c.seq    = seq;
        c.rd_en  = rd_en;
        c.mode   = mode;
        c.k      = k;
        c.decide = decide;
        c.commit = commit;
        return c;
    endfunction

    // microprogram: steps 1 to 11 each read one row, read data consumed in the following step
    always_comb
    begin
        unique case (step_reg)
            4'd0:    cw = mk(zglu_pkg::SQ_WAIT_IN,  1'b0, zglu_pkg::AM_SELF, 2'd0, 1'b0, 1'b0);
            4'd1:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_SELF,     2'd0, 1'b0, 1'b0);
            4'd2:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_PLUS_D,   2'd0, 1'b0, 1'b0);
            4'd3:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P,  2'd0, 1'b0, 1'b0);
            4'd4:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P,  2'd1, 1'b0, 1'b0);
            4'd5:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P,  2'd2, 1'b0, 1'b0);
            4'd6:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P_PLUS_D, 2'd0,
                             1'b0, 1'b0);
            4'd7:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P_PLUS_D, 2'd1,
                             1'b0, 1'b0);
            4'd8:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_MINUS_P_PLUS_D, 2'd2,
                             1'b0, 1'b0);
            4'd9:    cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_PLUS_P,   2'd0, 1'b0, 1'b0);
            4'd10:   cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_PLUS_P,   2'd1, 1'b0, 1'b0);
            4'd11:   cw = mk(zglu_pkg::SQ_NEXT, 1'b1, zglu_pkg::AM_PLUS_P,   2'd2, 1'b0, 1'b0);
            4'd12:   cw = mk(zglu_pkg::SQ_NEXT, 1'b0, zglu_pkg::AM_SELF,     2'd0, 1'b0, 1'b0);
            4'd13:   cw = mk(zglu_pkg::SQ_NEXT, 1'b0, zglu_pkg::AM_SELF,     2'd0, 1'b1, 1'b0);
            4'd14:   cw = mk(zglu_pkg::SQ_WAIT_OUT, 1'b0, zglu_pkg::AM_SELF, 2'd0, 1'b0, 1'b1);
            default: cw = mk(zglu_pkg::SQ_WAIT_IN,  1'b0, zglu_pkg::AM_SELF, 2'd0, 1'b0, 1'b0);
        endcase
    end

    always_comb
    begin
        unique case (cw.seq)
            zglu_pkg::SQ_WAIT_IN:  step_next = st.in_fire ? 4'd1 : step_reg;
            zglu_pkg::SQ_WAIT_OUT: step_next = st.out_free ? 4'd0 : step_reg;
            default:               step_next = step_reg + 4'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 4'd14)
        else $error("step counter out of program");

endmodule

/* sv/zglu_link_mem.sv */
`timescale 1ns / 1ps

module zglu_link_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  zglu_pkg::mem_req_t         req,
    output logic [zglu_pkg::DIRS-1:0]  rd_data,
    output logic                       ready
);

    logic [zglu_pkg::DIRS-1:0]  mem [zglu_pkg::ROW_DEPTH];
    logic [zglu_pkg::DIRS-1:0]  rd_data_reg;
    logic [zglu_pkg::ROW_W-1:0] clr_addr_reg;
    logic                       clr_busy_reg;

    // cold start: sweep all rows to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == zglu_pkg::ROW_W'(zglu_pkg::ROW_DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

    a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.wr_en && !req.rd_en)
        else $error("link store accessed during clear");

endmodule

/* sv/zglu_datapath.sv */
`timescale 1ns / 1ps

module zglu_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [zglu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [zglu_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [55:0]                        s_axis_tdata,
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,
    input  zglu_pkg::ctrl_t                    cw,
    output zglu_pkg::stat_t                    st,
    output zglu_pkg::mem_req_t                 req,
    input  logic [zglu_pkg::DIRS-1:0]          rd_data,
    input  logic                               mem_ready
);

    localparam int TW = zglu_pkg::TOTAL_W;

    // config
    logic [zglu_pkg::CFG_W-1:0] heat_s2_reg, heat_s4_reg, heat_s6_reg;
    logic [zglu_pkg::CFG_W-1:0] metro_e4_reg, metro_e8_reg, metro_e12_reg;

    // item
    logic [1:0]                  op_reg;
    logic [zglu_pkg::REP_W-1:0]  rep_reg;
    zglu_pkg::coord_t            crd_reg [4];
    logic [1:0]                  dir_reg;
    logic [31:0]                 rnd_reg;
    logic                        wv_reg;
    logic                        clr_reg;

    // staple parities, one bit per staple (1 means -1)
    logic [2:0]                  bwd_reg, fwd_reg;
    logic                        cons_vld_reg;
    zglu_pkg::adr_mode_t         cons_mode_reg;
    logic [1:0]                  cons_k_reg;
    logic [zglu_pkg::DIRS-1:0]   row_reg;
    logic                        old_reg;
    logic                        newb_reg;
    logic signed [3:0]           staple_reg;
    logic signed [TW-1:0]        acc_reg;

    // result
    logic                        m_valid_reg;
    logic                        m_old_reg, m_new_reg;
    logic signed [3:0]           m_staple_reg, m_term_reg;
    logic signed [TW-1:0]        m_total_reg;

    logic                        in_fire, out_free, commit;
    zglu_pkg::coord_t            c [4];
    logic [1:0]                  pk;
    logic [2:0]                  bwd_next, fwd_next;

    logic [2:0]                  cnt;
    logic signed [3:0]           half, ph, staple_next;
    logic [1:0]                  mag;
    logic [zglu_pkg::CFG_W-1:0]  u33, r_heat, r_clamp, thr_heat, thr_metro;
    logic                        accept, newb_next;

    logic signed [3:0]           term;
    logic signed [TW:0]          base, sum_wide;
    logic signed [TW-1:0]        total_next;
    logic [zglu_pkg::DIRS-1:0]   wr_row;

    assign s_axis_tready = (cw.seq == zglu_pkg::SQ_WAIT_IN) && mem_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign commit        = cw.commit && out_free;
    assign st.in_fire    = in_fire;
    assign st.out_free   = out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_s2_reg   <= zglu_pkg::HALF_PROB;
            heat_s4_reg   <= zglu_pkg::HALF_PROB;
            heat_s6_reg   <= zglu_pkg::HALF_PROB;
            metro_e4_reg  <= zglu_pkg::FULL_PROB;
            metro_e8_reg  <= zglu_pkg::FULL_PROB;
            metro_e12_reg <= zglu_pkg::FULL_PROB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                zglu_pkg::CFG_HEAT_S2:   heat_s2_reg   <= cfg_data;
                zglu_pkg::CFG_HEAT_S4:   heat_s4_reg   <= cfg_data;
                zglu_pkg::CFG_HEAT_S6:   heat_s6_reg   <= cfg_data;
                zglu_pkg::CFG_METRO_E4:  metro_e4_reg  <= cfg_data;
                zglu_pkg::CFG_METRO_E8:  metro_e8_reg  <= cfg_data;
                zglu_pkg::CFG_METRO_E12: metro_e12_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture; out-of-range fields fold back into the lattice
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= s_axis_tuser;
            rep_reg    <= zglu_pkg::REP_W'(s_axis_tdata[2:0] % zglu_pkg::REPLICAS);
            crd_reg[0] <= zglu_pkg::COORD_W'(s_axis_tdata[5:3] % zglu_pkg::LATTICE_SIDE);
            crd_reg[1] <= zglu_pkg::COORD_W'(s_axis_tdata[8:6] % zglu_pkg::LATTICE_SIDE);
            crd_reg[2] <= zglu_pkg::COORD_W'(s_axis_tdata[11:9] % zglu_pkg::LATTICE_SIDE);
            crd_reg[3] <= zglu_pkg::COORD_W'(s_axis_tdata[14:12] % zglu_pkg::LATTICE_SIDE);
            dir_reg    <= s_axis_tdata[16:15];
            rnd_reg    <= s_axis_tdata[48:17];
            wv_reg     <= s_axis_tdata[49];
            clr_reg    <= s_axis_tdata[50];
        end
    end

    // neighbor address
    always_comb
    begin
        pk = zglu_pkg::other_dir(dir_reg, cw.k);
        for (int i = 0; i < 4; i++)
            c[i] = crd_reg[i];
        case (cw.mode)
            zglu_pkg::AM_PLUS_D:  c[dir_reg] = zglu_pkg::step_up(crd_reg[dir_reg]);
            zglu_pkg::AM_MINUS_P: c[pk] = zglu_pkg::step_down(crd_reg[pk]);
            zglu_pkg::AM_MINUS_P_PLUS_D:
            begin
                c[pk]      = zglu_pkg::step_down(crd_reg[pk]);
                c[dir_reg] = zglu_pkg::step_up(crd_reg[dir_reg]);
            end
            zglu_pkg::AM_PLUS_P:  c[pk] = zglu_pkg::step_up(crd_reg[pk]);
            default: ;
        endcase
    end

    always_comb
    begin
        wr_row          = row_reg;
        wr_row[dir_reg] = newb_reg;
    end

    assign req.rd_en   = cw.rd_en;
    assign req.rd_addr = zglu_pkg::row_addr(rep_reg, c[0], c[1], c[2], c[3]);
    assign req.wr_en   = commit;
    assign req.wr_addr = req.rd_addr;
    assign req.wr_data = wr_row;

    // fold the row read in the previous step into the staple parities
    always_comb
    begin
        logic [1:0] cp;
        cp       = zglu_pkg::other_dir(dir_reg, cons_k_reg);
        bwd_next = bwd_reg;
        fwd_next = fwd_reg;
        if (cons_vld_reg)
        begin
            case (cons_mode_reg)
                zglu_pkg::AM_SELF, zglu_pkg::AM_PLUS_D:
                begin
                    for (int j = 0; j < 3; j++)
                        fwd_next[j] = fwd_reg[j] ^ rd_data[zglu_pkg::other_dir(dir_reg, 2'(j))];
                end
                zglu_pkg::AM_MINUS_P:
                    bwd_next[cons_k_reg] = bwd_reg[cons_k_reg] ^ rd_data[cp] ^ rd_data[dir_reg];
                zglu_pkg::AM_MINUS_P_PLUS_D:
                    bwd_next[cons_k_reg] = bwd_reg[cons_k_reg] ^ rd_data[cp];
                zglu_pkg::AM_PLUS_P:
                    fwd_next[cons_k_reg] = fwd_reg[cons_k_reg] ^ rd_data[dir_reg];
                default: ;
            endcase
        end
    end

    // update decision
    always_comb
    begin
        cnt = 3'(bwd_reg[0]) + 3'(bwd_reg[1]) + 3'(bwd_reg[2])
            + 3'(fwd_reg[0]) + 3'(fwd_reg[1]) + 3'(fwd_reg[2]);
        half        = 4'sd3 - $signed({1'b0, cnt});
        staple_next = $signed({half[2:0], 1'b0});
        mag         = half[3] ? 2'(-half) : half[1:0];
        u33         = {1'b0, rnd_reg};

        case (mag)
            2'd1:    r_heat = heat_s2_reg;
            2'd2:    r_heat = heat_s4_reg;
            2'd3:    r_heat = heat_s6_reg;
            default: r_heat = zglu_pkg::HALF_PROB;
        endcase
        r_clamp = r_heat[32] ? zglu_pkg::FULL_PROB : r_heat;
        if (half == 4'sd0)
            thr_heat = zglu_pkg::HALF_PROB;
        else if (!half[3])
            thr_heat = r_clamp;
        else
            thr_heat = zglu_pkg::FULL_PROB - r_clamp;

        ph = old_reg ? -half : half;
        case (ph[1:0])
            2'd1:    thr_metro = metro_e4_reg;
            2'd2:    thr_metro = metro_e8_reg;
            2'd3:    thr_metro = metro_e12_reg;
            default: thr_metro = zglu_pkg::FULL_PROB;
        endcase
        accept = ph[3] || (ph == 4'sd0) || (u33 < thr_metro);

        case (op_reg)
            zglu_pkg::OP_HEAT:    newb_next = !(u33 < thr_heat);
            zglu_pkg::OP_METRO:   newb_next = old_reg ^ accept;
            zglu_pkg::OP_MEASURE: newb_next = old_reg;
            zglu_pkg::OP_WRITE:   newb_next = wv_reg;
            default:              newb_next = old_reg;
        endcase
    end

    // running action sum with saturation
    always_comb
    begin
        term     = newb_reg ? -staple_reg : staple_reg;
        base     = clr_reg ? '0 : (TW+1)'(acc_reg);
        sum_wide = base + (TW+1)'(term);
        if (sum_wide > (TW+1)'(zglu_pkg::SUM_LIMIT))
            total_next = TW'(zglu_pkg::SUM_LIMIT);
        else if (sum_wide < -(TW+1)'(zglu_pkg::SUM_LIMIT))
            total_next = -TW'(zglu_pkg::SUM_LIMIT);
        else
            total_next = TW'(sum_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cons_vld_reg  <= 1'b0;
            cons_mode_reg <= zglu_pkg::AM_SELF;
            cons_k_reg    <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            cons_vld_reg  <= cw.rd_en;
            cons_mode_reg <= cw.mode;
            cons_k_reg    <= cw.k;
            if (commit)
            begin
                acc_reg     <= total_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bwd_reg <= '0;
            fwd_reg <= '0;
        end
        else
        begin
            bwd_reg <= bwd_next;
            fwd_reg <= fwd_next;
        end
        if (cons_vld_reg && cons_mode_reg == zglu_pkg::AM_SELF)
        begin
            row_reg <= rd_data;
            old_reg <= rd_data[dir_reg];
        end
        if (cw.decide)
        begin
            newb_reg   <= newb_next;
            staple_reg <= staple_next;
        end
        if (commit)
        begin
            m_old_reg    <= old_reg;
            m_new_reg    <= newb_reg;
            m_staple_reg <= staple_reg;
            m_term_reg   <= term;
            m_total_reg  <= total_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_total_reg, m_term_reg, m_staple_reg, m_new_reg, m_old_reg};

    a_staple_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !m_staple_reg[0])
        else $error("odd staple sum");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_total_reg <= TW'(zglu_pkg::SUM_LIMIT))
                     && (m_total_reg >= -TW'(zglu_pkg::SUM_LIMIT)))
        else $error("action sum beyond limit");

    a_term_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_term_reg == (m_new_reg ? -m_staple_reg : m_staple_reg))
        else $error("action term inconsistent with link");

    a_measure_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        commit && op_reg == zglu_pkg::OP_MEASURE |-> newb_reg == old_reg)
        else $error("measure changed a link");

endmodule

/* sv/z2_gauge_link_update_top.sv */
`timescale 1ns / 1ps
// Items: one item at a time; a new item is accepted only after the previous result has
// been committed. Per item, 11 link-store rows (4 links of a site) are read, one per
// read step, then one row is written back; the store has one read and one write port.
// Reset: async active low; thresholds go to defaults, action sum to zero, and the link
// store is swept row by row to cold (+1), during which no item is accepted.
module z2_gauge_link_update_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [32:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // replica, coord_t, coord_x, coord_y, coord_z, link_dir, random_word,
    // write_value, clear_sum
    input  logic [55:0] s_axis_tdata,
    // operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // old_link, new_link, staple_sum, action_term, action_total
    output logic [31:0] m_axis_tdata
);

    zglu_pkg::ctrl_t                   cw;
    zglu_pkg::stat_t                   st;
    zglu_pkg::mem_req_t                req;
    logic [zglu_pkg::DIRS-1:0]         rd_data;
    logic                              mem_ready;

    zglu_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cw    (cw)
    );

    zglu_link_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .ready   (mem_ready)
    );

    zglu_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cw            (cw),
        .st            (st),
        .req           (req),
        .rd_data       (rd_data),
        .mem_ready     (mem_ready)
    );

endmodule
